// ===== rtl/core/color_blend_adjust_pack_defines.svh =====
// Assertion macros shared by the color blend and pack RTL.
// Needs no other file; the including module supplies clock and reset names.
`ifndef COLOR_BLEND_ADJUST_PACK_DEFINES_SVH
`define COLOR_BLEND_ADJUST_PACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CBAP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CBAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cbap_pkg.sv =====
// Types, codes and the pixel packing function for the color blend and pack block.
// Depends on nothing; imported by color_blend_adjust_pack.
`timescale 1ns / 1ps
`default_nettype none

package cbap_pkg;

    localparam logic [1:0] FUNC_BLEND   = 2'd0;
    localparam logic [1:0] FUNC_LIGHTEN = 2'd1;
    localparam logic [1:0] FUNC_DARKEN  = 2'd2;

    localparam logic [2:0] FMT_INVALID  = 3'd0;
    localparam logic [2:0] FMT_RGB332   = 3'd1;
    localparam logic [2:0] FMT_RGB444   = 3'd2;
    localparam logic [2:0] FMT_RGB565   = 3'd3;
    localparam logic [2:0] FMT_RGB666   = 3'd4;
    localparam logic [2:0] FMT_RGB888   = 3'd5;
    localparam logic [2:0] FMT_RGBA8888 = 3'd6;

    localparam int NUM_CH    = 4;
    localparam int CH_ALPHA  = 3;

    // Q1.8 one.
    localparam logic [8:0] ONE_Q8 = 9'd256;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] color_self;
        logic [31:0] color_other;
        logic [8:0]  amount;
    } cbap_in_t;

    typedef struct packed {
        logic [31:0] color_out;
        logic [31:0] pixel_out;
    } cbap_out_t;

    function automatic logic [31:0] pack_pixel(input logic [31:0] c, input logic [2:0] fmt);
        logic [31:0] p;
        begin
            unique case (fmt)
                FMT_RGB332:   p = {24'd0, c[23:21], c[15:13], c[7:6]};
                FMT_RGB444:   p = {20'd0, c[23:20], c[15:12], c[7:4]};
                FMT_RGB565:   p = {16'd0, c[23:19], c[15:10], c[7:3]};
                FMT_RGB666:   p = {14'd0, c[23:18], c[15:10], c[7:2]};
                FMT_RGB888:   p = {8'd0, c[23:0]};
                FMT_RGBA8888: p = c;
                default:      p = 32'd0;
            endcase
            return p;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/color_blend_adjust_pack.sv =====
// Color blend / lighten / darken with pixel format packing, four register stages.
// Each input beat passes through the stage 1, 2, 3 and output registers in turn.
// Throughput: one beat per cycle; a stage holds while the next is full and stalled.
// Reset (aresetn, synchronous, active low) empties the pipeline and sets the
// pixel format to invalid; pixel_out is 0 for beats packed before a format write.
// Depends on cbap_pkg and color_blend_adjust_pack_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "color_blend_adjust_pack_defines.svh"

module color_blend_adjust_pack
    import cbap_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      cfg_we,
    input  wire logic [2:0] cfg_wdata,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire cbap_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output cbap_out_t      m_data
);

    logic [2:0] fmt_reg;

    // Stage 1: operands and factors.
    logic       vld1_reg;
    logic [7:0] x0_reg [NUM_CH];
    logic [7:0] x1_reg [NUM_CH];
    logic [9:0] f0_rgb_reg;
    logic [9:0] f0_a_reg;
    logic [8:0] f1_reg;

    // Stage 2: products.
    logic        vld2_reg;
    logic [17:0] p0_reg [NUM_CH];
    logic [16:0] p1_reg [NUM_CH];

    // Stage 3: saturated color.
    logic        vld3_reg;
    logic [31:0] color3_reg;

    // Stage 4: output register.
    logic        vld4_reg;
    cbap_out_t   out_reg;

    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !vld4_reg || m_ready;
    assign rdy3    = !vld3_reg || rdy4;
    assign rdy2    = !vld2_reg || rdy3;
    assign rdy1    = !vld1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = vld4_reg;
    assign m_data  = out_reg;

    // Decode the operation into a common form: sum of x0*f0 and x1*f1, each
    // truncated by 8 bits. Alpha gets its own f0 so adjust passes it through.
    logic [7:0] x0_next [NUM_CH];
    logic [7:0] x1_next [NUM_CH];
    logic [9:0] f0_rgb_next;
    logic [9:0] f0_a_next;
    logic [8:0] f1_next;
    logic [8:0] ratio;
    logic [8:0] dark;

    always_comb begin
        ratio = (s_data.amount > ONE_Q8) ? ONE_Q8 : s_data.amount;
        dark  = (s_data.amount >= ONE_Q8) ? 9'd0 : 9'(ONE_Q8 - s_data.amount);
        for (int ch = 0; ch < NUM_CH; ch++) begin
            x0_next[ch] = s_data.color_self[8*ch +: 8];
            x1_next[ch] = 8'd0;
        end
        f0_rgb_next = {1'b0, ONE_Q8};
        f0_a_next   = {1'b0, ONE_Q8};
        f1_next     = 9'd0;
        unique case (s_data.func)
            FUNC_BLEND: begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    x0_next[ch] = s_data.color_other[8*ch +: 8];
                    x1_next[ch] = s_data.color_self[8*ch +: 8];
                end
                f0_rgb_next = {1'b0, ratio};
                f0_a_next   = {1'b0, ratio};
                f1_next     = 9'(ONE_Q8 - ratio);
            end
            FUNC_LIGHTEN: f0_rgb_next = {1'b0, ONE_Q8} + {1'b0, s_data.amount};
            FUNC_DARKEN:  f0_rgb_next = {1'b0, dark};
            default:      f0_rgb_next = {1'b0, ONE_Q8};
        endcase
    end

    logic [17:0] p0_next [NUM_CH];
    logic [16:0] p1_next [NUM_CH];
    logic [31:0] color3_next;
    logic [10:0] sum [NUM_CH];

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            p0_next[ch] = {10'd0, x0_reg[ch]} *
                          ((ch == CH_ALPHA) ? {8'd0, f0_a_reg} : {8'd0, f0_rgb_reg});
            p1_next[ch] = {9'd0, x1_reg[ch]} * {8'd0, f1_reg};
        end
    end

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum[ch] = {1'b0, p0_reg[ch][17:8]} + {2'b00, p1_reg[ch][16:8]};
            color3_next[8*ch +: 8] = (sum[ch] > 11'd255) ? 8'hff : sum[ch][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= FMT_INVALID;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                fmt_reg <= cfg_wdata;
            end
            if (rdy1) begin
                vld1_reg <= s_valid;
            end
            if (rdy2) begin
                vld2_reg <= vld1_reg;
            end
            if (rdy3) begin
                vld3_reg <= vld2_reg;
            end
            if (rdy4) begin
                vld4_reg <= vld3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            x0_reg     <= x0_next;
            x1_reg     <= x1_next;
            f0_rgb_reg <= f0_rgb_next;
            f0_a_reg   <= f0_a_next;
            f1_reg     <= f1_next;
        end
        if (rdy2 && vld1_reg) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
        if (rdy3 && vld2_reg) begin
            color3_reg <= color3_next;
        end
        if (rdy4 && vld3_reg) begin
            out_reg.color_out <= color3_reg;
            out_reg.pixel_out <= pack_pixel(color3_reg, fmt_reg);
        end
    end

    `CBAP_ASSERT_NEXT(a_accept_fills_s1, aclk, aresetn, s_valid && s_ready, vld1_reg,
        "accepted input beat did not reach stage 1")
    `CBAP_ASSERT_NEXT(a_s3_to_out, aclk, aresetn, vld3_reg && rdy4, m_valid,
        "stage 3 beat did not reach the output register")
    `CBAP_ASSERT_NEXT(a_s3_holds, aclk, aresetn, vld3_reg && vld4_reg && !m_ready,
        vld3_reg && $stable(color3_reg), "stage 3 changed while the output was stalled")

endmodule

`default_nettype wire
